@@ design/tsb_pkg.sv @@
// ----------------------------------------------------------------------------
// tsb_pkg: shared types and constants for the timer slot bank
// Request, result, slot and state codes, the queued job word and field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsb_pkg;

  localparam int DATA_W = 32;
  localparam int SLOT_W = 6;

  typedef enum logic [1:0] {
    REQ_ARM_ONESHOT  = 2'd0,
    REQ_ARM_PERIODIC = 2'd1,
    REQ_DELETE       = 2'd2,
    REQ_TICK         = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_FREE     = 2'd0,
    KIND_ONESHOT  = 2'd1,
    KIND_PERIODIC = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    RES_ARMED   = 2'd0,
    RES_FULL    = 2'd1,
    RES_DELETED = 2'd2,
    RES_EXPIRY  = 2'd3
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_ARM_SCAN = 2'd1,
    ST_TICK_RUN = 2'd2,
    ST_TICK_END = 2'd3
  } state_t;

  // The amount holds the timeout for an arm and the elapsed ticks for a tick.
  typedef struct packed {
    req_t              req;
    kind_t             kind;
    logic [DATA_W-1:0] amount;
    logic [DATA_W-1:0] tag;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;
  } job_t;

  function automatic logic is_armed(input kind_t k);
    return (k == KIND_ONESHOT) || (k == KIND_PERIODIC);
  endfunction

endpackage

`default_nettype wire

@@ design/tsb_ram.sv @@
// ----------------------------------------------------------------------------
// tsb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/tsb_front.sv @@
// ----------------------------------------------------------------------------
// tsb_front: request intake and job queue
// Accepts requests, classifies them into jobs and holds them in a two-entry
// queue until the back end takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsb_front #(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 req_type,
  input  wire logic [tsb_pkg::DATA_W-1:0] timeout,
  input  wire logic [tsb_pkg::DATA_W-1:0] tag,
  input  wire logic [tsb_pkg::SLOT_W-1:0] slot,
  input  wire logic [tsb_pkg::DATA_W-1:0] ticks_elapsed,
  output logic                            job_valid,
  output tsb_pkg::job_t                   job,
  input  wire logic                       pop
);

  import tsb_pkg::*;

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  job_t       job_in;

  always_comb begin
    job_in.req     = req_t'(req_type);
    job_in.tag     = tag;
    job_in.slot    = slot;
    job_in.slot_ok = ({1'b0, slot} < (SLOT_W + 1)'(NUM_SLOTS));
    job_in.kind    = KIND_ONESHOT;
    job_in.amount  = timeout;
    unique case (req_t'(req_type))
      REQ_ARM_PERIODIC: begin
        job_in.kind = KIND_PERIODIC;
      end
      REQ_TICK: begin
        job_in.amount = ticks_elapsed;
      end
      default: begin
      end
    endcase
  end

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign job_valid = (count != 2'd0);
  assign job       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= job_in;
    end
  end

endmodule

`default_nettype wire

@@ design/tsb_back.sv @@
// ----------------------------------------------------------------------------
// tsb_back: slot table engine
// Runs queued jobs against the slot table: free-slot scan for arms, direct
// delete, and a pipelined sweep over all slots for ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsb_back #(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       job_valid,
  input  wire tsb_pkg::job_t              job,
  output logic                            pop,
  output logic                            strobe,
  output logic [1:0]                      result_kind,
  output logic [tsb_pkg::SLOT_W-1:0]      slot_index,
  output logic [tsb_pkg::DATA_W-1:0]      expired_tag,
  output logic [tsb_pkg::DATA_W-1:0]      period,
  output logic                            last
);

  import tsb_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  state_t            state;
  state_t            state_next;
  job_t              cur;
  kind_t             kind [NUM_SLOTS];
  logic [IW-1:0]     idx;
  logic              idx_last;
  logic              issue_done;
  logic              issuing;
  logic              wb_valid;
  logic [IW-1:0]     wb_idx;
  kind_t             scan_kind;
  kind_t             wb_kind;
  logic              wb_expire;

  logic [DATA_W-1:0] rem_rdata;
  logic [DATA_W-1:0] tag_rdata;
  logic [DATA_W-1:0] reload_rdata;

  logic              hold_valid;
  logic [IW-1:0]     hold_idx;
  logic [DATA_W-1:0] hold_tag;
  logic [DATA_W-1:0] hold_period;
  logic              hold_load;
  logic              hold_clear;

  logic              kind_we;
  logic [IW-1:0]     kind_waddr;
  kind_t             kind_wdata;
  logic              arm_we;
  logic              rem_we;
  logic [IW-1:0]     rem_waddr;
  logic [DATA_W-1:0] rem_wdata;

  logic              out_fire;
  res_t              out_kind;
  logic [SLOT_W-1:0] out_slot;
  logic [DATA_W-1:0] out_tag;
  logic [DATA_W-1:0] out_period;
  logic              out_last;

  assign idx_last  = (idx == IW'(NUM_SLOTS - 1));
  assign scan_kind = kind[idx];
  assign wb_kind   = kind[wb_idx];
  assign wb_expire = (cur.amount >= rem_rdata);
  assign issuing   = (state == ST_TICK_RUN) && !issue_done;

  tsb_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS), .AW(IW)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (idx),
    .rdata (rem_rdata)
  );

  tsb_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS), .AW(IW)) u_tag_ram (
    .clk   (clk),
    .we    (arm_we),
    .waddr (idx),
    .wdata (cur.tag),
    .raddr (idx),
    .rdata (tag_rdata)
  );

  tsb_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS), .AW(IW)) u_reload_ram (
    .clk   (clk),
    .we    (arm_we),
    .waddr (idx),
    .wdata (cur.amount),
    .raddr (idx),
    .rdata (reload_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (job_valid) begin
          case (job.req) inside
            REQ_ARM_ONESHOT, REQ_ARM_PERIODIC: state_next = ST_ARM_SCAN;
            REQ_TICK:                          state_next = ST_TICK_RUN;
            default:                           state_next = ST_IDLE;
          endcase
        end
      end
      ST_ARM_SCAN: begin
        if (!is_armed(scan_kind) || idx_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_TICK_RUN: begin
        if (issue_done && !wb_valid) begin
          state_next = ST_TICK_END;
        end
      end
      ST_TICK_END: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    kind_we    = 1'b0;
    kind_waddr = idx;
    kind_wdata = KIND_FREE;
    arm_we     = 1'b0;
    rem_we     = 1'b0;
    rem_waddr  = idx;
    rem_wdata  = cur.amount;
    hold_load  = 1'b0;
    hold_clear = 1'b0;
    out_fire   = 1'b0;
    out_kind   = RES_ARMED;
    out_slot   = '0;
    out_tag    = '0;
    out_period = '0;
    out_last   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        pop = job_valid;
        if (job_valid && (job.req == REQ_DELETE)) begin
          out_fire   = 1'b1;
          out_kind   = RES_DELETED;
          out_slot   = job.slot;
          kind_we    = job.slot_ok;
          kind_waddr = job.slot[IW-1:0];
        end
      end
      ST_ARM_SCAN: begin
        if (!is_armed(scan_kind)) begin
          kind_we    = 1'b1;
          kind_wdata = cur.kind;
          arm_we     = 1'b1;
          rem_we     = 1'b1;
          out_fire   = 1'b1;
          out_slot   = SLOT_W'(idx);
        end else if (idx_last) begin
          out_fire = 1'b1;
          out_kind = RES_FULL;
        end
      end
      ST_TICK_RUN: begin
        rem_waddr  = wb_idx;
        kind_waddr = wb_idx;
        if (wb_valid && is_armed(wb_kind)) begin
          if (wb_expire) begin
            hold_load = 1'b1;
            if (hold_valid) begin
              out_fire   = 1'b1;
              out_kind   = RES_EXPIRY;
              out_slot   = SLOT_W'(hold_idx);
              out_tag    = hold_tag;
              out_period = hold_period;
              out_last   = 1'b0;
            end
            if (wb_kind == KIND_PERIODIC) begin
              rem_we    = 1'b1;
              rem_wdata = reload_rdata;
            end else begin
              kind_we = 1'b1;
            end
          end else begin
            rem_we    = 1'b1;
            rem_wdata = rem_rdata - cur.amount;
          end
        end
      end
      ST_TICK_END: begin
        hold_clear = 1'b1;
        if (hold_valid) begin
          out_fire   = 1'b1;
          out_kind   = RES_EXPIRY;
          out_slot   = SLOT_W'(hold_idx);
          out_tag    = hold_tag;
          out_period = hold_period;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issue_done <= 1'b0;
      wb_valid   <= 1'b0;
      hold_valid <= 1'b0;
      strobe     <= 1'b0;
      idx        <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        kind[i] <= KIND_FREE;
      end
    end else begin
      state    <= state_next;
      wb_valid <= issuing;
      strobe   <= out_fire;
      if (kind_we) begin
        kind[kind_waddr] <= kind_wdata;
      end
      if (state == ST_IDLE) begin
        idx        <= '0;
        issue_done <= 1'b0;
      end else if ((state == ST_ARM_SCAN) && is_armed(scan_kind) && !idx_last) begin
        idx <= idx + IW'(1);
      end else if (issuing) begin
        if (idx_last) begin
          issue_done <= 1'b1;
        end else begin
          idx <= idx + IW'(1);
        end
      end
      if (hold_load) begin
        hold_valid <= 1'b1;
      end else if (hold_clear) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_idx <= idx;
    if (pop) begin
      cur <= job;
    end
    if (hold_load) begin
      hold_idx    <= wb_idx;
      hold_tag    <= tag_rdata;
      hold_period <= reload_rdata;
    end
    result_kind <= out_kind;
    slot_index  <= out_slot;
    expired_tag <= out_tag;
    period      <= out_period;
    last        <= out_last;
  end

endmodule

`default_nettype wire

@@ design/timer_slot_bank_top.sv @@
// ----------------------------------------------------------------------------
// timer_slot_bank_top: table of one-shot and periodic timer slots
// Arms slots in the lowest free place, deletes slots, and on each tick
// counts every armed slot down and reports the ones that expire.
//
//   Channel   Handshake              Words
//   request   start / busy           req_type, timeout, tag, slot, ticks_elapsed
//   result    strobe, one cycle      result_kind, slot_index, expired_tag,
//                                    period, last
//
// A delete is done by the back end straight from idle, an arm scans for a
// free slot from the lowest up (at most NUM_SLOTS of them), and a tick
// sweeps the remaining count RAM one slot per cycle, through every slot.
// A two-entry queue lets requests arrive while a job runs.
// Reset clears the slot kinds at once; requests are taken the next cycle.
// Results cannot be held off and appear as soon as they are known.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timer_slot_bank_top #(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 req_type,
  input  wire logic [tsb_pkg::DATA_W-1:0] timeout,
  input  wire logic [tsb_pkg::DATA_W-1:0] tag,
  input  wire logic [tsb_pkg::SLOT_W-1:0] slot,
  input  wire logic [tsb_pkg::DATA_W-1:0] ticks_elapsed,
  output logic                            strobe,
  output logic [1:0]                      result_kind,
  output logic [tsb_pkg::SLOT_W-1:0]      slot_index,
  output logic [tsb_pkg::DATA_W-1:0]      expired_tag,
  output logic [tsb_pkg::DATA_W-1:0]      period,
  output logic                            last
);

  import tsb_pkg::*;

  logic job_valid;
  job_t job;
  logic pop;

  tsb_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .timeout       (timeout),
    .tag           (tag),
    .slot          (slot),
    .ticks_elapsed (ticks_elapsed),
    .job_valid     (job_valid),
    .job           (job),
    .pop           (pop)
  );

  tsb_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (job),
    .pop         (pop),
    .strobe      (strobe),
    .result_kind (result_kind),
    .slot_index  (slot_index),
    .expired_tag (expired_tag),
    .period      (period),
    .last        (last)
  );

endmodule

`default_nettype wire
